[rtl/core/dtc_pkg.sv]
// Shared types and arithmetic helpers of the temporal clamp deinterlacer.
`default_nettype none

package dtc_pkg;

  localparam int unsigned PixW = 8;

  typedef logic [PixW-1:0] pix_t;

  // Signed pixel difference (one extra bit) and its negation range.
  typedef logic signed [PixW:0]   sdiff_t;
  typedef logic signed [PixW+1:0] swide_t;

  // Payload after the first stage: averages and absolute differences.
  typedef struct packed {
    pix_t              p2;
    logic [PixW-2:0]   d0;
    pix_t              a1;
    pix_t              b1;
    pix_t              a2;
    pix_t              b2;
    pix_t              ta;
    pix_t              tb;
    pix_t              p1;
    pix_t              p3;
    pix_t              sp;
    logic              en;
  } s1_t;

  // Payload after the second stage: temporal deviation and edge extremes.
  typedef struct packed {
    pix_t   p2;
    pix_t   diff_t;
    sdiff_t mx;
    sdiff_t mn;
    pix_t   sp;
    logic   en;
  } s2_t;

  // Payload after the third stage: final allowed deviation.
  typedef struct packed {
    pix_t p2;
    pix_t diff;
    pix_t sp;
  } s3_t;

  // Rounded mean (a+b+1)/2 of two pixels.
  function automatic pix_t avg_rnd(input pix_t a, input pix_t b);
    logic [PixW:0] sum;
    sum = {1'b0, a} + {1'b0, b} + {{PixW{1'b0}}, 1'b1};
    return sum[PixW:1];
  endfunction

  // Absolute difference of two pixels.
  function automatic pix_t abs_d(input pix_t a, input pix_t b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // Signed difference a - b of two pixels.
  function automatic sdiff_t sub_s(input pix_t a, input pix_t b);
    return sdiff_t'({1'b0, a}) - sdiff_t'({1'b0, b});
  endfunction

endpackage

`default_nettype wire

[rtl/core/dtc_temporal.sv]
// First pipeline stage: temporal average, center half difference and line distances.
`default_nettype none

module dtc_temporal (
  input  logic          clk_i,
  input  logic          load_i,
  input  dtc_pkg::pix_t cur_above_i,
  input  dtc_pkg::pix_t cur_below_i,
  input  logic [15:0]   prev_above_below_i,
  input  logic [15:0]   next_above_below_i,
  input  dtc_pkg::pix_t tm_prev_center_i,
  input  dtc_pkg::pix_t tm_next_center_i,
  input  logic [15:0]   tm_prev_two_off_i,
  input  logic [15:0]   tm_next_two_off_i,
  input  dtc_pkg::pix_t interp_pix_i,
  input  logic          en_i,
  output dtc_pkg::s1_t  s1_o
);
  import dtc_pkg::*;

  s1_t  s1_d, s1_q;
  pix_t cdiff;

  // Split the packed neighbor pairs and form the per-pixel terms.
  always_comb begin
    cdiff     = abs_d(tm_prev_center_i, tm_next_center_i);
    s1_d.p2   = avg_rnd(tm_prev_center_i, tm_next_center_i);
    s1_d.d0   = cdiff[PixW-1:1];
    s1_d.a1   = abs_d(prev_above_below_i[15:8], cur_above_i);
    s1_d.b1   = abs_d(prev_above_below_i[7:0], cur_below_i);
    s1_d.a2   = abs_d(next_above_below_i[15:8], cur_above_i);
    s1_d.b2   = abs_d(next_above_below_i[7:0], cur_below_i);
    s1_d.ta   = avg_rnd(tm_prev_two_off_i[15:8], tm_next_two_off_i[15:8]);
    s1_d.tb   = avg_rnd(tm_prev_two_off_i[7:0], tm_next_two_off_i[7:0]);
    s1_d.p1   = cur_above_i;
    s1_d.p3   = cur_below_i;
    s1_d.sp   = interp_pix_i;
    s1_d.en   = en_i;
  end

  // Stage register.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      s1_q <= s1_d;
    end
  end

  assign s1_o = s1_q;

endmodule

`default_nettype wire

[rtl/core/dtc_bound.sv]
// Second and third pipeline stages: temporal deviation, edge test and final deviation.
`default_nettype none

module dtc_bound (
  input  logic         clk_i,
  input  logic         load2_i,
  input  logic         load3_i,
  input  dtc_pkg::s1_t s1_i,
  output dtc_pkg::s3_t s3_o
);
  import dtc_pkg::*;

  s2_t    s2_d, s2_q;
  s3_t    s3_d, s3_q;
  pix_t   d1, d2, d0w, dm;
  sdiff_t e1, e3, e0, e4;
  sdiff_t mx_a, mx_b, mn_a, mn_b;
  swide_t neg_mx, sc;

  // Stage two: largest temporal difference and the edge extremes.
  always_comb begin
    d1  = avg_rnd(s1_i.a1, s1_i.b1);
    d2  = avg_rnd(s1_i.a2, s1_i.b2);
    d0w = {1'b0, s1_i.d0};
    dm  = (d1 > d2) ? d1 : d2;
    e1  = sub_s(s1_i.p2, s1_i.p1);
    e3  = sub_s(s1_i.p2, s1_i.p3);
    e0  = sub_s(s1_i.ta, s1_i.p1);
    e4  = sub_s(s1_i.tb, s1_i.p3);
    mx_a = (e1 > e3) ? e1 : e3;
    mx_b = (e0 < e4) ? e0 : e4;
    mn_a = (e1 < e3) ? e1 : e3;
    mn_b = (e0 > e4) ? e0 : e4;
    s2_d.p2     = s1_i.p2;
    s2_d.diff_t = (d0w > dm) ? d0w : dm;
    s2_d.mx     = (mx_a > mx_b) ? mx_a : mx_b;
    s2_d.mn     = (mn_a < mn_b) ? mn_a : mn_b;
    s2_d.sp     = s1_i.sp;
    s2_d.en     = s1_i.en;
  end

  // Stage three: the edge test may widen the deviation. The widened value
  // never exceeds a pixel range, since both extremes lie within it.
  always_comb begin
    neg_mx = -swide_t'(s2_q.mx);
    sc     = (swide_t'(s2_q.mn) > neg_mx) ? swide_t'(s2_q.mn) : neg_mx;
    s3_d.p2   = s2_q.p2;
    s3_d.sp   = s2_q.sp;
    s3_d.diff = s2_q.diff_t;
    if (s2_q.en && (sc > swide_t'({2'b00, s2_q.diff_t}))) begin
      s3_d.diff = sc[PixW-1:0];
    end
  end

  // Stage registers.
  always_ff @(posedge clk_i) begin
    if (load2_i) begin
      s2_q <= s2_d;
    end
    if (load3_i) begin
      s3_q <= s3_d;
    end
  end

  assign s3_o = s3_q;

endmodule

`default_nettype wire

[rtl/core/deinterlace_temporal_clamp.sv]
// Stages in order: first, second, third and the output register. Throughput:
// one pixel per cycle while the output does not stall; each of the four stages
// holds one item, loads when empty or its successor moves; bubbles close up.
// Reset: all stage valid bits clear and the spatial check enable returns to 1.
// Stage payload registers are not reset.
`default_nettype none

module deinterlace_temporal_clamp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  dtc_pkg::pix_t cur_above_i,
  input  dtc_pkg::pix_t cur_below_i,
  input  logic [15:0]   prev_above_below_i,
  input  logic [15:0]   next_above_below_i,
  input  dtc_pkg::pix_t tm_prev_center_i,
  input  dtc_pkg::pix_t tm_next_center_i,
  input  logic [15:0]   tm_prev_two_off_i,
  input  logic [15:0]   tm_next_two_off_i,
  input  dtc_pkg::pix_t interp_pix_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output dtc_pkg::pix_t out_pixel_o
);
  import dtc_pkg::*;

  localparam int unsigned NumStages = 4;

  logic                 en_q;
  logic [NumStages-1:0] v_q, v_d;
  logic [NumStages-1:0] rdy;
  s1_t                  s1;
  s3_t                  s3;
  swide_t               hi, lo, r0, r1;
  pix_t                 pix_d, pix_q;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b1;
    end else if (cfg_we_i) begin
      en_q <= cfg_wdata_i;
    end
  end

  // Per-stage ready: a stage may load when empty or when its content moves on.
  always_comb begin
    rdy[NumStages-1] = !v_q[NumStages-1] || !out_stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
    v_d[0] = rdy[0] ? in_valid_i : v_q[0];
    for (int k = 1; k < NumStages; k++) begin
      v_d[k] = rdy[k] ? v_q[k-1] : v_q[k];
    end
  end

  // Valid bits travel with the stage payloads.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = v_q[NumStages-1];

  dtc_temporal u_temporal (
    .clk_i              (clk_i),
    .load_i             (rdy[0]),
    .cur_above_i        (cur_above_i),
    .cur_below_i        (cur_below_i),
    .prev_above_below_i (prev_above_below_i),
    .next_above_below_i (next_above_below_i),
    .tm_prev_center_i   (tm_prev_center_i),
    .tm_next_center_i   (tm_next_center_i),
    .tm_prev_two_off_i  (tm_prev_two_off_i),
    .tm_next_two_off_i  (tm_next_two_off_i),
    .interp_pix_i       (interp_pix_i),
    .en_i               (en_q),
    .s1_o               (s1)
  );

  dtc_bound u_bound (
    .clk_i   (clk_i),
    .load2_i (rdy[1]),
    .load3_i (rdy[2]),
    .s1_i    (s1),
    .s3_o    (s3)
  );

  // Last stage: clamp the spatial prediction to the temporal window.
  always_comb begin
    hi = swide_t'({2'b00, s3.p2}) + swide_t'({2'b00, s3.diff});
    lo = swide_t'({2'b00, s3.p2}) - swide_t'({2'b00, s3.diff});
    r0 = swide_t'({2'b00, s3.sp});
    r1 = (r0 > hi) ? hi : r0;
    r1 = (r1 < lo) ? lo : r1;
    pix_d = r1[PixW-1:0];
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (rdy[NumStages-1]) begin
      pix_q <= pix_d;
    end
  end

  assign out_pixel_o = pix_q;

  // The input is held back only when every stage is full and the output waits.
  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> ((&v_q) && out_stall_i))
    else $error("input stalled while the pipeline has room");

  // An empty pipeline always takes a transfer.
  a_empty_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q == '0) |-> !in_stall_o)
    else $error("empty pipeline stalls the input");

  // A waiting result keeps its value.
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_pixel_o)))
    else $error("waiting result lost or changed");

  // A blocked third stage keeps its item.
  a_s3_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[2] && !rdy[2]) |=> (v_q[2] && $stable(s3)))
    else $error("blocked stage three lost or changed its item");

  // An accepted transfer shows up in the first stage.
  a_s1_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v_q[0])
    else $error("accepted transfer not captured");

endmodule

`default_nettype wire

[sim/testbench.sv]
// Self-checking testbench for the temporal clamp deinterlacer pixel pipeline.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef dtc_pkg::pix_t pix_t;

  // One neighborhood of the missing pixel, in port order.
  typedef struct packed {
    pix_t        cur_above;
    pix_t        cur_below;
    logic [15:0] prev_above_below;
    logic [15:0] next_above_below;
    pix_t        tm_prev_center;
    pix_t        tm_next_center;
    logic [15:0] tm_prev_two_off;
    logic [15:0] tm_next_two_off;
    pix_t        interp_pix;
  } neighborhood_t;

  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned SettleCycles = 8;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_wdata_i = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  pix_t out_pixel_o;

  neighborhood_t on_bus = '0;
  neighborhood_t pending_pixels[$];
  pix_t clamped_pixels[$];

  bit spatial_check_en = 1'b1;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int fail_count = 0;
  int unsigned quiet_cycles = 0;

  deinterlace_temporal_clamp dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .cur_above_i        (on_bus.cur_above),
    .cur_below_i        (on_bus.cur_below),
    .prev_above_below_i (on_bus.prev_above_below),
    .next_above_below_i (on_bus.next_above_below),
    .tm_prev_center_i   (on_bus.tm_prev_center),
    .tm_next_center_i   (on_bus.tm_next_center),
    .tm_prev_two_off_i  (on_bus.tm_prev_two_off),
    .tm_next_two_off_i  (on_bus.tm_next_two_off),
    .interp_pix_i       (on_bus.interp_pix),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_pixel_o        (out_pixel_o)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int rnd_mean(int a, int b);
    return (a + b + 1) / 2;
  endfunction

  function automatic int absdist(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic int imax(int a, int b);
    return (a > b) ? a : b;
  endfunction

  function automatic int imin(int a, int b);
    return (a < b) ? a : b;
  endfunction

  // Spatial prediction clamped to the temporal mean plus or minus the allowed deviation.
  function automatic pix_t clamp_to_temporal(neighborhood_t nb, bit edge_check);
    int p1, p3, pa, pb, na, nbl, tp, tn, tpu, tpd, tnu, tnd, sp;
    int mean, dev, e1, e3, e0, e4, top, bot, r;
    p1 = int'(nb.cur_above);
    p3 = int'(nb.cur_below);
    pa = int'(nb.prev_above_below[15:8]);
    pb = int'(nb.prev_above_below[7:0]);
    na = int'(nb.next_above_below[15:8]);
    nbl = int'(nb.next_above_below[7:0]);
    tp = int'(nb.tm_prev_center);
    tn = int'(nb.tm_next_center);
    tpu = int'(nb.tm_prev_two_off[15:8]);
    tpd = int'(nb.tm_prev_two_off[7:0]);
    tnu = int'(nb.tm_next_two_off[15:8]);
    tnd = int'(nb.tm_next_two_off[7:0]);
    sp = int'(nb.interp_pix);
    mean = rnd_mean(tp, tn);
    dev = imax(absdist(tp, tn) / 2,
               imax(rnd_mean(absdist(pa, p1), absdist(pb, p3)),
                    rnd_mean(absdist(na, p1), absdist(nbl, p3))));
    // The edge test may only widen the deviation.
    if (edge_check) begin
      e1 = mean - p1;
      e3 = mean - p3;
      e0 = rnd_mean(tpu, tnu) - p1;
      e4 = rnd_mean(tpd, tnd) - p3;
      top = imax(imax(e1, e3), imin(e0, e4));
      bot = imin(imin(e1, e3), imax(e0, e4));
      dev = imax(dev, imax(bot, -top));
    end
    r = sp;
    if (r > mean + dev) r = mean + dev;
    if (r < mean - dev) r = mean - dev;
    return pix_t'(r);
  endfunction

  function automatic neighborhood_t pix_item(int p1, int p3, int pa, int pb,
                                             int na, int nb, int tp, int tn,
                                             int tpu, int tpd, int tnu, int tnd,
                                             int sp);
    neighborhood_t it;
    it.cur_above = pix_t'(p1);
    it.cur_below = pix_t'(p3);
    it.prev_above_below = {pix_t'(pa), pix_t'(pb)};
    it.next_above_below = {pix_t'(na), pix_t'(nb)};
    it.tm_prev_center = pix_t'(tp);
    it.tm_next_center = pix_t'(tn);
    it.tm_prev_two_off = {pix_t'(tpu), pix_t'(tpd)};
    it.tm_next_two_off = {pix_t'(tnu), pix_t'(tnd)};
    it.interp_pix = pix_t'(sp);
    return it;
  endfunction

  // Pixel close to a base value, kept inside the pixel range.
  function automatic int near(int base, int spread);
    int v;
    v = base + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v;
  endfunction

  // Smooth neighborhoods half of the time so the clamp bites, plus noise and saturated values.
  function automatic neighborhood_t random_item();
    neighborhood_t it;
    logic [127:0] raw;
    int kind, base, spread;
    kind = $urandom_range(0, 9);
    raw = {$urandom, $urandom, $urandom, $urandom};
    if (kind < 3) begin
      it = raw[$bits(neighborhood_t)-1:0];
    end else if (kind < 5) begin
      it = raw[$bits(neighborhood_t)-1:0];
      for (int b = 0; b < $bits(neighborhood_t) / 8; b++) begin
        it[b*8 +: 8] = $urandom_range(0, 1) ? 8'hff : 8'h00;
      end
    end else begin
      base = $urandom_range(0, 255);
      spread = $urandom_range(0, 12);
      it = pix_item(near(base, spread), near(base, spread), near(base, spread),
                    near(base, spread), near(base, spread), near(base, spread),
                    near(base, spread), near(base, spread), near(base, spread),
                    near(base, spread), near(base, spread), near(base, spread),
                    $urandom_range(0, 1) ? int'($urandom_range(0, 255))
                                         : near(base, 4 * spread + 4));
    end
    return it;
  endfunction

  // Corners of the field ranges, rounding points and both directions of the edge test.
  task automatic push_directed();
    pending_pixels.push_back(pix_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_pixels.push_back(pix_item(255, 255, 255, 255, 255, 255, 255, 255,
                                      255, 255, 255, 255, 255));
    pending_pixels.push_back(pix_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 255));
    pending_pixels.push_back(pix_item(255, 255, 255, 255, 255, 255, 255, 255,
                                      255, 255, 255, 255, 0));
    pending_pixels.push_back(pix_item(128, 128, 128, 128, 128, 128, 0, 255,
                                      128, 128, 128, 128, 0));
    pending_pixels.push_back(pix_item(0, 255, 255, 0, 0, 255, 128, 128,
                                      128, 128, 128, 128, 255));
    pending_pixels.push_back(pix_item(0, 0, 0, 0, 0, 0, 200, 200, 200, 200, 200, 200, 17));
    pending_pixels.push_back(pix_item(255, 255, 255, 255, 255, 255, 50, 50,
                                      50, 50, 50, 50, 250));
    pending_pixels.push_back(pix_item(100, 100, 100, 100, 100, 100, 110, 110,
                                      0, 255, 0, 255, 0));
    pending_pixels.push_back(pix_item(0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 255));
    pending_pixels.push_back(pix_item(255, 255, 255, 255, 255, 255, 254, 255,
                                      255, 255, 255, 255, 0));
    pending_pixels.push_back(pix_item(10, 20, 13, 24, 10, 20, 15, 15, 15, 15, 15, 15, 0));
  endtask

  // Wait until every queued pixel went through and the pipeline has emptied.
  task automatic drain();
    while (pending_pixels.size() != 0 || in_valid_i || clamped_pixels.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_spatial_check(bit value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    spatial_check_en = value;
  endtask

  task automatic run_random(int count, int src_pct, int sink_pct);
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
    for (int i = 0; i < count; i++) begin
      pending_pixels.push_back(random_item());
    end
    drain();
  endtask

  // Input driver: predicts on each accepted transfer and offers the next pixel.
  always @(posedge clk_i) begin
    neighborhood_t next_item;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        clamped_pixels.push_back(clamp_to_temporal(on_bus, spatial_check_en));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_pixels.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          next_item = pending_pixels.pop_front();
          on_bus <= next_item;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor: compares each output transfer and draws the next stall.
  always @(posedge clk_i) begin
    pix_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (clamped_pixels.size() == 0) begin
          $error("out_pixel: no pixel expected, actual %0d", out_pixel_o);
          fail_count++;
        end else begin
          want = clamped_pixels.pop_front();
          if (out_pixel_o !== want) begin
            $error("out_pixel: expected %0d, actual %0d", want, out_pixel_o);
            fail_count++;
          end
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < sink_stall_pct);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Test sequence: directed pixels under both settings, then random phases.
  initial begin
    bit en;
    int mode;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The enable comes out of reset set.
    push_directed();
    drain();
    write_spatial_check(1'b0);
    push_directed();
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      en = ((ph % 2) != 0) ^ (((ph / 4) % 2) != 0);
      mode = ph % 4;
      write_spatial_check(en);
      case (mode)
        0: run_random(165, 0, 0);
        1: run_random(165, 85, 0);
        2: run_random(165, 0, 85);
        default: run_random(165, 28, 28);
      endcase
    end

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
